/* rtl/core/ssfb_pkg.sv */
`default_nettype none

package ssfb_pkg;

   localparam logic [7:0] CMD_DATA = 8'h40;
   localparam logic [7:0] CMD_ADDR = 8'hC0;
   localparam logic [7:0] CMD_CTRL = 8'h80;

   localparam logic [1:0] MODE_NUMBER = 2'd0;
   localparam logic [1:0] MODE_TIME   = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [1:0] REG_BRIGHTNESS   = 2'd0;
   localparam logic [1:0] REG_DISPLAY_ON   = 2'd1;
   localparam logic [1:0] REG_BLINK_ENABLE = 2'd2;
   localparam logic [1:0] REG_DOT_SEGMENTS = 2'd3;

   localparam int RAW_W = 14;

   localparam logic [2:0] TICK_POSITION   = 3'd4;
   localparam logic [2:0] HOUR_COUNT      = 3'd4;
   localparam logic [2:0] HOUR_POSITION   = 3'd0;
   localparam logic [2:0] MINUTE_COUNT    = 3'd2;
   localparam logic [2:0] MINUTE_POSITION = 3'd2;
   localparam logic [7:0] NOTHING_SHOWN   = 8'hFF;
   localparam logic [7:0] DOTS_RESET      = 8'h80;

   typedef struct packed {
      logic       tick;
      logic [7:0] dots;
      logic       lead_zero;
      logic [2:0] count;
      logic [2:0] position;
      logic [7:0] tick_seg;
   } job_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0: seg = 8'h3F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic longint unsigned pow10(input int n);
      longint unsigned r;
      r = 64'd1;
      for (int i = 0; i < n; i++) begin
         r = r * 64'd10;
      end
      return r;
   endfunction

   function automatic int value_width(input int n);
      return $clog2(pow10(n));
   endfunction

endpackage

`default_nettype wire

/* rtl/core/ssfb_fifo.sv */
`default_nettype none

module ssfb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ssfb_front.sv */
`default_nettype none

module ssfb_front
   import ssfb_pkg::*;
#(
   parameter int DIGIT_POSITIONS = 4,
   parameter int VW              = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [1:0]    req_mode,
   input  wire logic [13:0]   req_number,
   input  wire logic [7:0]    req_dots,
   input  wire logic          req_leading_zero,
   input  wire logic [2:0]    req_digit_count,
   input  wire logic [2:0]    req_position,
   input  wire logic [6:0]    req_hours,
   input  wire logic [6:0]    req_minutes,
   input  wire logic          blink_enable,
   input  wire logic [7:0]    dot_segments,
   output logic               job_push,
   output job_type            job_data,
   output logic      [VW-1:0] job_value,
   input  wire logic          job_full
);

   localparam longint unsigned LIMIT = pow10(DIGIT_POSITIONS);
   localparam int CW = (VW > RAW_W) ? VW : RAW_W;
   localparam logic [CW-1:0] MAXV = CW'(LIMIT - 64'd1);

   logic [7:0]       shown_hour_ff, shown_hour_in;
   logic [7:0]       shown_minute_ff, shown_minute_in;
   logic             dots_lit_ff, dots_lit_in;
   logic             accept, has_job;
   logic [RAW_W-1:0] hours_x100, time_raw, raw;
   logic [CW-1:0]    raw_ext, sat;

   assign accept     = req_push && !job_full;
   assign req_full   = job_full;
   assign hours_x100 = RAW_W'(req_hours) * RAW_W'(100);
   assign time_raw   = hours_x100 + RAW_W'(req_minutes);
   assign raw_ext    = CW'(raw);
   assign sat        = (raw_ext > MAXV) ? MAXV : raw_ext;
   assign job_value  = VW'(sat);
   assign job_push   = accept && has_job;

   always_comb begin
      has_job         = 1'b0;
      job_data        = '0;
      raw             = req_number;
      shown_hour_in   = shown_hour_ff;
      shown_minute_in = shown_minute_ff;
      dots_lit_in     = dots_lit_ff;
      case (req_mode)
         MODE_NUMBER: begin
            has_job            = 1'b1;
            job_data.dots      = req_dots;
            job_data.lead_zero = req_leading_zero;
            job_data.count     = req_digit_count;
            job_data.position  = req_position;
         end
         MODE_TIME: begin
            if ({1'b0, req_hours} != shown_hour_ff) begin
               has_job           = 1'b1;
               raw               = time_raw;
               job_data.count    = HOUR_COUNT;
               job_data.position = HOUR_POSITION;
               if (accept) begin
                  shown_hour_in   = {1'b0, req_hours};
                  shown_minute_in = {1'b0, req_minutes};
               end
            end else if ({1'b0, req_minutes} != shown_minute_ff) begin
               has_job            = 1'b1;
               raw                = RAW_W'(req_minutes);
               job_data.lead_zero = 1'b1;
               job_data.count     = MINUTE_COUNT;
               job_data.position  = MINUTE_POSITION;
               if (accept) begin
                  shown_minute_in = {1'b0, req_minutes};
               end
            end
         end
         MODE_TICK: begin
            if (blink_enable) begin
               has_job           = 1'b1;
               job_data.tick     = 1'b1;
               job_data.count    = 3'd1;
               job_data.position = TICK_POSITION;
               job_data.tick_seg = dots_lit_ff ? dot_segments : 8'h00;
               if (accept) begin
                  dots_lit_in = !dots_lit_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_hour_ff   <= NOTHING_SHOWN;
         shown_minute_ff <= NOTHING_SHOWN;
         dots_lit_ff     <= 1'b0;
      end else begin
         shown_hour_ff   <= shown_hour_in;
         shown_minute_ff <= shown_minute_in;
         dots_lit_ff     <= dots_lit_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ssfb_digits.sv */
`default_nettype none

module ssfb_digits
   import ssfb_pkg::*;
#(
   parameter int DIGIT_POSITIONS = 4,
   parameter int VW              = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          job_empty,
   input  wire job_type       job_data,
   input  wire logic [VW-1:0] job_value,
   output logic               job_pop,
   output logic               out_valid,
   output job_type            out_job,
   output logic      [3:0]    out_digits [DIGIT_POSITIONS],
   input  wire logic          out_take
);

   localparam int SW = $clog2(DIGIT_POSITIONS + 1);
   localparam int S  = VW + 3;
   localparam longint unsigned RECIP = ((64'd1 << S) + 64'd9) / 64'd10;
   localparam int PW = VW + S;

   typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} conv_state_type;

   conv_state_type state_ff, state_in;
   logic [SW-1:0]  step_ff, step_in;
   logic [VW-1:0]  quo_ff, quo_in;
   logic [3:0]     prev_ff, prev_in;
   job_type        job_ff, job_in;
   logic [3:0]     digit_ff [DIGIT_POSITIONS];
   logic [PW-1:0]  prod;
   logic [3:0]     ten_q, new_digit;
   logic           shift;

   assign prod      = PW'(quo_ff) * PW'(RECIP);
   assign ten_q     = {quo_ff[0], 3'b000} + {quo_ff[2:0], 1'b0};
   assign new_digit = prev_ff - ten_q;
   assign out_valid = (state_ff == C_DONE);
   assign out_job   = job_ff;
   assign out_digits = digit_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      prev_in  = prev_ff;
      job_in   = job_ff;
      job_pop  = 1'b0;
      shift    = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               quo_in   = job_value;
               step_in  = '0;
               state_in = job_data.tick ? C_DONE : C_RUN;
            end
         end
         C_RUN: begin
            quo_in  = prod[S +: VW];
            prev_in = quo_ff[3:0];
            step_in = step_ff + SW'(1);
            shift   = (step_ff != '0);
            if (step_ff == SW'(DIGIT_POSITIONS)) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            if (out_take) begin
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      prev_ff <= prev_in;
      job_ff  <= job_in;
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         digit_ff[0] <= new_digit;
         for (int i = 1; i < DIGIT_POSITIONS; i++) begin
            digit_ff[i] <= digit_ff[i-1];
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/ssfb_emit.sv */
`default_nettype none

module ssfb_emit
   import ssfb_pkg::*;
#(
   parameter int DIGIT_POSITIONS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       conv_valid,
   input  wire job_type    conv_job,
   input  wire logic [3:0] conv_digits [DIGIT_POSITIONS],
   output logic            conv_take,
   input  wire logic [2:0] brightness_level,
   input  wire logic       display_on,
   output logic            out_push,
   output rsp_type         out_data,
   input  wire logic       out_full
);

   localparam int LW = $clog2(DIGIT_POSITIONS + 1);
   localparam int IW = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;

   typedef enum logic [2:0] {E_IDLE, E_DATA, E_ADDR, E_SEG, E_CTRL} emit_state_type;

   emit_state_type state_ff, state_in;
   logic [7:0]     segs_ff [DIGIT_POSITIONS];
   logic [7:0]     seg_load [DIGIT_POSITIONS];
   logic [LW-1:0]  rem_ff, rem_in, len;
   logic [IW-1:0]  sp_ff, sp_in;
   logic [2:0]     pos_ff, pos_in;
   logic           tick_ff, tick_in;
   logic [7:0]     tick_seg_ff, tick_seg_in;
   logic           seen, nonzero, blank;

   always_comb begin
      seen    = 1'b0;
      nonzero = 1'b0;
      blank   = 1'b0;
      for (int k = 0; k < DIGIT_POSITIONS; k++) begin
         nonzero = (conv_digits[k] != 4'd0);
         blank = !conv_job.lead_zero && !nonzero && !seen && (k != DIGIT_POSITIONS - 1);
         seen = seen | nonzero;
         seg_load[k] = (blank ? 8'h00 : seg_of(conv_digits[k])) | {conv_job.dots[7-k], 7'd0};
      end
   end

   always_comb begin
      if (int'(conv_job.count) > DIGIT_POSITIONS) begin
         len = LW'(DIGIT_POSITIONS);
      end else begin
         len = LW'(conv_job.count);
      end
   end

   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      sp_in       = sp_ff;
      pos_in      = pos_ff;
      tick_in     = tick_ff;
      tick_seg_in = tick_seg_ff;
      conv_take   = 1'b0;
      out_push    = 1'b0;
      out_data    = '0;
      case (state_ff)
         E_IDLE: begin
            if (conv_valid) begin
               conv_take   = 1'b1;
               tick_in     = conv_job.tick;
               tick_seg_in = conv_job.tick_seg;
               pos_in      = conv_job.position;
               if (conv_job.tick) begin
                  rem_in = LW'(1);
                  sp_in  = '0;
               end else begin
                  rem_in = len;
                  sp_in  = IW'(DIGIT_POSITIONS - int'(len));
               end
               state_in = E_DATA;
            end
         end
         E_DATA: begin
            out_push              = !out_full;
            out_data.bus_byte     = CMD_DATA;
            out_data.start_before = 1'b1;
            out_data.stop_after   = 1'b1;
            if (!out_full) begin
               state_in = E_ADDR;
            end
         end
         E_ADDR: begin
            out_push              = !out_full;
            out_data.bus_byte     = CMD_ADDR + {5'd0, pos_ff};
            out_data.start_before = 1'b1;
            out_data.stop_after   = (rem_ff == '0);
            if (!out_full) begin
               state_in = (rem_ff == '0) ? E_CTRL : E_SEG;
            end
         end
         E_SEG: begin
            out_push            = !out_full;
            out_data.bus_byte   = tick_ff ? tick_seg_ff : segs_ff[sp_ff];
            out_data.stop_after = (rem_ff == LW'(1));
            if (!out_full) begin
               rem_in = rem_ff - LW'(1);
               sp_in  = sp_ff + IW'(1);
               if (rem_ff == LW'(1)) begin
                  state_in = E_CTRL;
               end
            end
         end
         E_CTRL: begin
            out_push              = !out_full;
            out_data.bus_byte     = CMD_CTRL + {4'd0, display_on, brightness_level};
            out_data.start_before = 1'b1;
            out_data.stop_after   = 1'b1;
            out_data.last         = 1'b1;
            if (!out_full) begin
               state_in = E_IDLE;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff      <= rem_in;
      sp_ff       <= sp_in;
      pos_ff      <= pos_in;
      tick_ff     <= tick_in;
      tick_seg_ff <= tick_seg_in;
   end

   always_ff @(posedge clock) begin
      if (conv_take) begin
         segs_ff <= seg_load;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/seven_segment_frame_builder.sv */
// Builds the command byte stream of a multi-digit seven-segment controller.
// Requests enter through a queue-style port: a transaction is taken when
// req_push is high and req_full is low. Each request yields zero to
// DIGIT_POSITIONS + 3 bytes on the rsp_ side, which also looks like a queue:
// the oldest byte is shown while rsp_empty is low and leaves on rsp_pop.
// Registers are written over the csr_ port, which is always ready.
// A request is classified combinationally and, if it yields bytes, written into
// the job queue. The digit unit peels one decimal digit per cycle with a
// reciprocal multiply and takes a new job only once the byte emitter has taken
// its previous result, so it converts the next request while bytes are sent.
// When the receiver stalls, the output queue fills, the emitter and digit unit
// hold, and req_full rises once the request queue is full; nothing is lost.
// Reset empties all queues, forgets the shown time, clears the dot phase and
// returns the registers to their reset values.
`default_nettype none

module seven_segment_frame_builder
   import ssfb_pkg::*;
#(
   parameter int DIGIT_POSITIONS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_mode,
   input  wire logic [13:0] req_number,
   input  wire logic [7:0]  req_dots,
   input  wire logic        req_leading_zero,
   input  wire logic [2:0]  req_digit_count,
   input  wire logic [2:0]  req_position,
   input  wire logic [6:0]  req_hours,
   input  wire logic [6:0]  req_minutes,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_bus_byte,
   output logic             rsp_start_before,
   output logic             rsp_stop_after,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int VW = value_width(DIGIT_POSITIONS);
   localparam int JB = $bits(job_type);
   localparam int JW = JB + VW;
   localparam int RB = $bits(rsp_type);

   logic [2:0]    brightness_ff, brightness_in;
   logic          display_on_ff, display_on_in;
   logic          blink_enable_ff, blink_enable_in;
   logic [7:0]    dot_segments_ff, dot_segments_in;
   logic          csr_write;

   logic          job_push, job_full, job_pop, job_empty;
   job_type       job_wr, job_rd;
   logic [VW-1:0] job_wr_value;
   logic [JW-1:0] job_rdata;

   logic          conv_valid, conv_take;
   job_type       conv_job;
   logic [3:0]    conv_digits [DIGIT_POSITIONS];

   logic          out_push, out_full;
   rsp_type       out_data, out_rd;
   logic [RB-1:0] out_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      brightness_in   = brightness_ff;
      display_on_in   = display_on_ff;
      blink_enable_in = blink_enable_ff;
      dot_segments_in = dot_segments_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_BRIGHTNESS:   brightness_in   = csr_pwdata[2:0];
            REG_DISPLAY_ON:   display_on_in   = csr_pwdata[0];
            REG_BLINK_ENABLE: blink_enable_in = csr_pwdata[0];
            REG_DOT_SEGMENTS: dot_segments_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BRIGHTNESS:   csr_prdata = {29'd0, brightness_ff};
         REG_DISPLAY_ON:   csr_prdata = {31'd0, display_on_ff};
         REG_BLINK_ENABLE: csr_prdata = {31'd0, blink_enable_ff};
         REG_DOT_SEGMENTS: csr_prdata = {24'd0, dot_segments_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff   <= '0;
         display_on_ff   <= 1'b0;
         blink_enable_ff <= 1'b1;
         dot_segments_ff <= DOTS_RESET;
      end else begin
         brightness_ff   <= brightness_in;
         display_on_ff   <= display_on_in;
         blink_enable_ff <= blink_enable_in;
         dot_segments_ff <= dot_segments_in;
      end
   end

   ssfb_front #(
      .DIGIT_POSITIONS (DIGIT_POSITIONS),
      .VW              (VW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_number       (req_number),
      .req_dots         (req_dots),
      .req_leading_zero (req_leading_zero),
      .req_digit_count  (req_digit_count),
      .req_position     (req_position),
      .req_hours        (req_hours),
      .req_minutes      (req_minutes),
      .blink_enable     (blink_enable_ff),
      .dot_segments     (dot_segments_ff),
      .job_push         (job_push),
      .job_data         (job_wr),
      .job_value        (job_wr_value),
      .job_full         (job_full)
   );

   ssfb_fifo #(
      .WIDTH (JW),
      .DEPTH (2)
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata ({job_wr, job_wr_value}),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rdata),
      .empty (job_empty)
   );

   assign job_rd = job_type'(job_rdata[JW-1 -: JB]);

   ssfb_digits #(
      .DIGIT_POSITIONS (DIGIT_POSITIONS),
      .VW              (VW)
   ) u_digits (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_data   (job_rd),
      .job_value  (job_rdata[VW-1:0]),
      .job_pop    (job_pop),
      .out_valid  (conv_valid),
      .out_job    (conv_job),
      .out_digits (conv_digits),
      .out_take   (conv_take)
   );

   ssfb_emit #(
      .DIGIT_POSITIONS (DIGIT_POSITIONS)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .conv_valid       (conv_valid),
      .conv_job         (conv_job),
      .conv_digits      (conv_digits),
      .conv_take        (conv_take),
      .brightness_level (brightness_ff),
      .display_on       (display_on_ff),
      .out_push         (out_push),
      .out_data         (out_data),
      .out_full         (out_full)
   );

   ssfb_fifo #(
      .WIDTH (RB),
      .DEPTH (2)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign out_rd           = rsp_type'(out_rdata);
   assign rsp_bus_byte     = out_rd.bus_byte;
   assign rsp_start_before = out_rd.start_before;
   assign rsp_stop_after   = out_rd.stop_after;
   assign rsp_last         = out_rd.last;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("Output queue not empty after reset.");

   a_last_is_ctrl: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last |-> rsp_bus_byte[7:4] == CMD_CTRL[7:4])
      else $error("The final byte of a transaction is not a control command.");

   a_open_is_addr: assert property (@(posedge clock) disable iff (reset)
      out_push && out_data.start_before && !out_data.stop_after
      |-> out_data.bus_byte[7:3] == CMD_ADDR[7:3])
      else $error("An open frame does not start with an address command.");
`endif

endmodule

`default_nettype wire

/* sim/seven_segment_frame_builder_checker.sv */
`timescale 1ns / 1ps

module seven_segment_frame_builder_checker
   import ssfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [13:0] req_number,
   input  logic [7:0]  req_dots,
   input  logic        req_leading_zero,
   input  logic [2:0]  req_digit_count,
   input  logic [2:0]  req_position,
   input  logic [6:0]  req_hours,
   input  logic [6:0]  req_minutes,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_bus_byte,
   input  logic        rsp_start_before,
   input  logic        rsp_stop_after,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   localparam int DIGITS = 4;
   localparam int unsigned MAX_SHOWN = 9999;
   // Segment patterns for the digits 9 down to 0, digit d at bits [8*d +: 8].
   localparam logic [79:0] GLYPHS = 80'h6F_7F_07_7D_6D_66_4F_5B_06_3F;

   logic [2:0] brightness;
   logic       display_on;
   logic       blink_enable;
   logic [7:0] dot_pattern;
   logic [7:0] shown_hour;
   logic [7:0] shown_minute;
   logic       dots_lit;

   rsp_type expected_bytes[$];

   function automatic void push_byte(input logic [7:0] value, input logic start,
                                     input logic stop, input logic final_byte);
      rsp_type entry;
      entry.bus_byte     = value;
      entry.start_before = start;
      entry.stop_after   = stop;
      entry.last         = final_byte;
      expected_bytes.push_back(entry);
   endfunction

   function automatic void queue_frame(input logic [8*DIGITS-1:0] glyphs, input int first,
                                       input int count, input logic [2:0] pos);
      push_byte(CMD_DATA, 1'b1, 1'b1, 1'b0);
      push_byte(CMD_ADDR + {5'd0, pos}, 1'b1, count == 0, 1'b0);
      for (int k = 0; k < count; k++) begin
         push_byte(glyphs[8*(first + k) +: 8], 1'b0, k == count - 1, 1'b0);
      end
      push_byte(CMD_CTRL + {4'd0, display_on, brightness}, 1'b1, 1'b1, 1'b1);
   endfunction

   function automatic void queue_number(input int unsigned value, input logic [7:0] dot_bits,
                                        input logic show_zeros, input int count,
                                        input logic [2:0] pos);
      logic [8*DIGITS-1:0] glyphs;
      int unsigned divisor;
      int unsigned digit;
      logic        leading;
      logic [7:0]  pattern;
      if (value > MAX_SHOWN) value = MAX_SHOWN;
      if (count > DIGITS) count = DIGITS;
      leading = 1'b1;
      divisor = 1000;
      for (int k = 0; k < DIGITS; k++) begin
         digit = (value / divisor) % 10;
         if (digit != 0) leading = 1'b0;
         if (digit == 0 && !show_zeros && leading && k != DIGITS - 1) begin
            pattern = 8'h00;
         end else begin
            pattern = GLYPHS[8*digit +: 8];
         end
         glyphs[8*k +: 8] = pattern | {dot_bits[7-k], 7'd0};
         divisor = divisor / 10;
      end
      queue_frame(glyphs, DIGITS - count, count, pos);
   endfunction

   function automatic void predict_request();
      case (req_mode)
         MODE_NUMBER: begin
            queue_number(int'(req_number), req_dots, req_leading_zero,
                         int'(req_digit_count), req_position);
         end
         MODE_TIME: begin
            if ({1'b0, req_hours} != shown_hour) begin
               shown_hour   = {1'b0, req_hours};
               shown_minute = {1'b0, req_minutes};
               queue_number(int'(req_hours) * 100 + int'(req_minutes), 8'h00, 1'b0,
                            int'(HOUR_COUNT), HOUR_POSITION);
            end else if ({1'b0, req_minutes} != shown_minute) begin
               shown_minute = {1'b0, req_minutes};
               queue_number(int'(req_minutes), 8'h00, 1'b1, int'(MINUTE_COUNT),
                            MINUTE_POSITION);
            end
         end
         MODE_TICK: begin
            if (blink_enable) begin
               queue_frame({24'd0, dots_lit ? dot_pattern : 8'h00}, 0, 1, TICK_POSITION);
               dots_lit = !dots_lit;
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         brightness   = 3'd0;
         display_on   = 1'b0;
         blink_enable = 1'b1;
         dot_pattern  = DOTS_RESET;
         shown_hour   = NOTHING_SHOWN;
         shown_minute = NOTHING_SHOWN;
         dots_lit     = 1'b0;
         expected_bytes.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BRIGHTNESS:   brightness   = csr_pwdata[2:0];
               REG_DISPLAY_ON:   display_on   = csr_pwdata[0];
               REG_BLINK_ENABLE: blink_enable = csr_pwdata[0];
               REG_DOT_SEGMENTS: dot_pattern  = csr_pwdata[7:0];
               default: begin
               end
            endcase
         end
         if (req_push && !req_full) predict_request();
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected transaction, got byte %h start %b stop %b last %b",
                        $time, rsp_bus_byte, rsp_start_before, rsp_stop_after, rsp_last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_bytes.pop_front();
               if (want.bus_byte !== rsp_bus_byte || want.start_before !== rsp_start_before ||
                   want.stop_after !== rsp_stop_after || want.last !== rsp_last) begin
                  $display("%0t: expected byte %h start %b stop %b last %b, got %h %b %b %b",
                           $time, want.bus_byte, want.start_before, want.stop_after,
                           want.last, rsp_bus_byte, rsp_start_before, rsp_stop_after,
                           rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_bytes.size();
   end

endmodule

/* sim/seven_segment_frame_builder_tb.sv */
`timescale 1ns / 1ps

module seven_segment_frame_builder_tb;
   import ssfb_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_mode = MODE_NUMBER;
   logic [13:0] req_number = '0;
   logic [7:0]  req_dots = '0;
   logic        req_leading_zero = 1'b0;
   logic [2:0]  req_digit_count = '0;
   logic [2:0]  req_position = '0;
   logic [6:0]  req_hours = '0;
   logic [6:0]  req_minutes = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_start_before;
   logic        rsp_stop_after;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   logic [6:0] last_hour = '0;
   logic [6:0] last_minute = '0;

   always #5 clock = ~clock;

   seven_segment_frame_builder dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_mode(req_mode),
      .req_number(req_number), .req_dots(req_dots), .req_leading_zero(req_leading_zero),
      .req_digit_count(req_digit_count), .req_position(req_position),
      .req_hours(req_hours), .req_minutes(req_minutes),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_bus_byte(rsp_bus_byte),
      .rsp_start_before(rsp_start_before), .rsp_stop_after(rsp_stop_after),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   seven_segment_frame_builder_checker frame_check (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_mode(req_mode),
      .req_number(req_number), .req_dots(req_dots), .req_leading_zero(req_leading_zero),
      .req_digit_count(req_digit_count), .req_position(req_position),
      .req_hours(req_hours), .req_minutes(req_minutes),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_bus_byte(rsp_bus_byte),
      .rsp_start_before(rsp_start_before), .rsp_stop_after(rsp_stop_after),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   task automatic send(input logic [1:0] mode, input logic [13:0] number,
                       input logic [7:0] dots, input logic show_zeros,
                       input logic [2:0] count, input logic [2:0] pos,
                       input logic [6:0] hours, input logic [6:0] minutes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_mode         <= mode;
      req_number       <= number;
      req_dots         <= dots;
      req_leading_zero <= show_zeros;
      req_digit_count  <= count;
      req_position     <= pos;
      req_hours        <= hours;
      req_minutes      <= minutes;
      req_push         <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [2:0] level, input logic on, input logic blink,
                            input logic [7:0] pattern);
      write_reg(REG_BRIGHTNESS, {29'd0, level});
      write_reg(REG_DISPLAY_ON, {31'd0, on});
      write_reg(REG_BLINK_ENABLE, {31'd0, blink});
      write_reg(REG_DOT_SEGMENTS, {24'd0, pattern});
   endtask

   // Time requests mostly repeat the shown hour so that minute-only updates
   // and unchanged times are reached besides full rewrites.
   task automatic send_random(input logic blink, inout int counted);
      int unsigned pick;
      int unsigned range_sel;
      logic [1:0]  mode;
      logic [13:0] number;
      logic [6:0]  hours;
      logic [6:0]  minutes;
      pick = $urandom_range(99);
      mode = pick < 45 ? MODE_NUMBER : pick < 75 ? MODE_TIME : pick < 95 ? MODE_TICK
           : MODE_UNUSED;
      range_sel = $urandom_range(3);
      case (range_sel)
         0: number = 14'($urandom_range(9));
         1: number = 14'($urandom_range(999));
         2: number = 14'($urandom_range(9999));
         default: number = 14'($urandom_range(16383));
      endcase
      hours = last_hour;
      minutes = last_minute;
      pick = $urandom_range(9);
      if (pick < 4) begin
         hours = $urandom_range(9) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(23));
      end
      if (pick < 8) begin
         minutes = $urandom_range(9) == 0 ? 7'($urandom_range(127)) : 7'($urandom_range(59));
      end
      if (mode == MODE_TIME) begin
         last_hour = hours;
         last_minute = minutes;
      end
      send(mode, number, 8'($urandom_range(255)), 1'($urandom_range(1)),
           3'($urandom_range(7)), 3'($urandom_range(7)), hours, minutes);
      if (mode == MODE_NUMBER || mode == MODE_TIME || (mode == MODE_TICK && blink)) begin
         counted++;
      end
   endtask

   initial begin
      int counted;
      logic blink;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(MODE_NUMBER, 14'd0, 8'h00, 1'b0, 3'd4, 3'd0, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'd0, 8'h00, 1'b1, 3'd4, 3'd0, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'd9999, 8'hFF, 1'b0, 3'd4, 3'd7, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'h3FFF, 8'hAA, 1'b1, 3'd7, 3'd1, 7'h7F, 7'h7F);
      send(MODE_NUMBER, 14'd1005, 8'h55, 1'b0, 3'd0, 3'd5, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'd40, 8'h55, 1'b0, 3'd3, 3'd3, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'd7, 8'h01, 1'b0, 3'd1, 3'd6, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'd200, 8'h0F, 1'b0, 3'd5, 3'd2, 7'd0, 7'd0);
      send(MODE_TIME, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd12, 7'd34);
      send(MODE_TIME, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd12, 7'd34);
      send(MODE_TIME, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd12, 7'd5);
      send(MODE_TIME, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd127, 7'd127);
      send(MODE_TIME, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd0, 7'd0);
      send(MODE_TIME, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd0, 7'd127);
      send(MODE_TICK, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd0, 7'd0);
      send(MODE_TICK, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd0, 7'd0);
      send(MODE_TICK, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd0, 7'd0);
      send(MODE_UNUSED, 14'h3FFF, 8'hFF, 1'b1, 3'd7, 3'd7, 7'h7F, 7'h7F);

      drain();
      configure(3'd7, 1'b1, 1'b0, 8'hFF);
      send(MODE_TICK, 14'd0, 8'h00, 1'b0, 3'd0, 3'd0, 7'd0, 7'd0);
      send(MODE_NUMBER, 14'd1234, 8'h80, 1'b1, 3'd4, 3'd0, 7'd0, 7'd0);
      last_hour = 7'd0;
      last_minute = 7'd127;

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin
               blink = 1'b1;
               configure(3'd0, 1'b0, blink, 8'h00);
               send_idle_pct <= 0;
               pop_stall_pct <= 0;
            end
            1: begin
               blink = 1'b0;
               configure(3'd7, 1'b1, blink, 8'hFF);
               send_idle_pct <= 52;
               pop_stall_pct <= 0;
            end
            2: begin
               blink = 1'b1;
               configure(3'($urandom_range(7)), 1'b1, blink, 8'($urandom_range(255)));
               send_idle_pct <= 0;
               pop_stall_pct <= 52;
            end
            default: begin
               blink = 1'b1;
               configure(3'd3, 1'b0, blink, 8'h80);
               send_idle_pct <= 8;
               pop_stall_pct <= 8;
            end
         endcase
         counted = 0;
         while (counted < 110) send_random(blink, counted);
      end

      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
rtl/core/ssfb_pkg.sv
rtl/core/ssfb_fifo.sv
rtl/core/ssfb_front.sv
rtl/core/ssfb_digits.sv
rtl/core/ssfb_emit.sv
rtl/core/seven_segment_frame_builder.sv
sim/seven_segment_frame_builder_checker.sv
sim/seven_segment_frame_builder_tb.sv
